FILE: design/gray_page_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gray page classifier
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef GRAY_PAGE_CLASSIFIER_CORE_MACROS_SVH
`define GRAY_PAGE_CLASSIFIER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// check that is suspended while reset is high
`define GPC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gray page classifier: assertion failed");
// check that also runs through reset
`define GPC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gray page classifier: reset assertion failed");
`else
`define GPC_ASSERT(label, clk, rst, prop)
`define GPC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: design/gpc_pkg.sv
// ----------------------------------------------------------------------------
// Gray page classifier package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package gpc_pkg;

  // luma weights, sum to 256
  localparam logic [7:0] W_RED   = 8'd77;
  localparam logic [7:0] W_GREEN = 8'd150;
  localparam logic [7:0] W_BLUE  = 8'd29;

  localparam logic [6:0] PCT_SCALE = 7'd100;

  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam int unsigned CFG_DATA_WIDTH  = 8;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_NEUTRAL_TOLERANCE = 3'd0,
    CFG_GRAY_PERCENT      = 3'd1,
    CFG_BAND_LOW          = 3'd2,
    CFG_BAND_HIGH         = 3'd3,
    CFG_MIDTONE_PERCENT   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] neutral_tolerance;
    logic [6:0] gray_percent;
    logic [7:0] band_low;
    logic [7:0] band_high;
    logic [6:0] midtone_percent;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    neutral_tolerance: 8'd2,
    gray_percent:      7'd90,
    band_low:          8'd50,
    band_high:         8'd200,
    midtone_percent:   7'd5
  };

  typedef struct packed {
    logic [7:0] luma;
    logic       neutral;
    logic       midtone;
  } pix_eval_t;

endpackage

FILE: design/gpc_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel stream interface
// One RGB pixel per transaction, with an end-of-page mark.
// ----------------------------------------------------------------------------
interface gpc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, output red, output green, output blue,
                  output last_pixel, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input last_pixel, output ready);
endinterface

FILE: design/gpc_result_if.sv
// ----------------------------------------------------------------------------
// Result stream interface
// Luma and neutral flag per pixel, page verdicts on the last pixel.
// ----------------------------------------------------------------------------
interface gpc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       pixel_neutral;
  logic       page_end;
  logic       page_gray;
  logic       bilevel_ready;

  modport source (output valid, output luma, output pixel_neutral, output page_end,
                  output page_gray, output bilevel_ready, input ready);
  modport sink   (input valid, input luma, input pixel_neutral, input page_end,
                  input page_gray, input bilevel_ready, output ready);
endinterface

FILE: design/gpc_pixel_eval.sv
// ----------------------------------------------------------------------------
// Pixel evaluation
// Weighted luma, neutral test on all channel pairs, mid-tone band test.
// ----------------------------------------------------------------------------
module gpc_pixel_eval
  import gpc_pkg::*;
(
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  cfg_t       cfg,
  output pix_eval_t  eval
);

  logic [15:0] weighted_sum;
  logic [7:0]  diff_rg;
  logic [7:0]  diff_rb;
  logic [7:0]  diff_gb;
  logic [7:0]  luma;

  always_comb begin
    weighted_sum = 16'(W_RED) * 16'(red) + 16'(W_GREEN) * 16'(green)
                 + 16'(W_BLUE) * 16'(blue);
    luma    = weighted_sum[15:8];
    diff_rg = (red > green) ? red - green : green - red;
    diff_rb = (red > blue) ? red - blue : blue - red;
    diff_gb = (green > blue) ? green - blue : blue - green;
  end

  assign eval.luma    = luma;
  assign eval.neutral = (diff_rg < cfg.neutral_tolerance) &&
                        (diff_rb < cfg.neutral_tolerance) &&
                        (diff_gb < cfg.neutral_tolerance);
  assign eval.midtone = (luma > cfg.band_low) && (luma < cfg.band_high);

endmodule

FILE: design/gray_page_classifier_core.sv
// Throughput: one pixel per cycle while result.ready holds, set by the
// five-register pipeline with per-stage bubble collapsing; a stalled result
// does not block empty stages.
// Reset (rst, synchronous, active high) empties the pipeline, clears the
// page counters and loads the configuration defaults.
// ----------------------------------------------------------------------------
// Gray page classifier core
// Per-pixel luma and neutral flag, page gray and bilevel-ready verdicts.
// ----------------------------------------------------------------------------
`include "gray_page_classifier_core_macros.svh"

module gray_page_classifier_core
  import gpc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  gpc_pixel_if.sink                  pixel,
  gpc_result_if.source               result,
  input  logic                       write_enable,
  input  logic [CFG_INDEX_WIDTH-1:0] write_index,
  input  logic [CFG_DATA_WIDTH-1:0]  write_data
);

  localparam int unsigned PROD_WIDTH = COUNT_WIDTH + 7;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // configuration
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (write_enable) begin
      case (write_index)
        CFG_NEUTRAL_TOLERANCE: cfg.neutral_tolerance <= write_data;
        CFG_GRAY_PERCENT:      cfg.gray_percent      <= write_data[6:0];
        CFG_BAND_LOW:          cfg.band_low          <= write_data;
        CFG_BAND_HIGH:         cfg.band_high         <= write_data;
        CFG_MIDTONE_PERCENT:   cfg.midtone_percent   <= write_data[6:0];
        default: ;
      endcase
    end
  end

  // pipeline valid bits and load enables
  logic s1_valid, s2_valid, s3_valid, s4_valid, out_valid;
  logic ld1, ld2, ld3, ld4, ld_out;

  assign ld_out = !out_valid || result.ready;
  assign ld4    = !s4_valid || ld_out;
  assign ld3    = !s3_valid || ld4;
  assign ld2    = !s2_valid || ld3;
  assign ld1    = !s1_valid || ld2;
  assign pixel.ready = ld1;

  // stage 1: input register
  logic [7:0] s1_red, s1_green, s1_blue;
  logic       s1_last;

  // stage 2: evaluated pixel
  pix_eval_t  s1_eval;
  pix_eval_t  s2_eval;
  logic       s2_last;

  // stage 3: page counts snapshot
  logic [7:0]             s3_luma;
  logic                   s3_neutral;
  logic                   s3_last;
  logic [COUNT_WIDTH-1:0] s3_neutral_count, s3_midtone_count, s3_pixel_count;

  // stage 4: scaled products
  logic [7:0]            s4_luma;
  logic                  s4_neutral;
  logic                  s4_last;
  logic [PROD_WIDTH-1:0] s4_neutral_scaled, s4_gray_limit;
  logic [PROD_WIDTH-1:0] s4_midtone_scaled, s4_midtone_limit;

  // running page counters
  logic [COUNT_WIDTH-1:0] neutral_count, midtone_count, pixel_count;
  logic [COUNT_WIDTH-1:0] neutral_count_next, midtone_count_next, pixel_count_next;
  logic                   count_advance;

  gpc_pixel_eval u_eval (
    .red   (s1_red),
    .green (s1_green),
    .blue  (s1_blue),
    .cfg   (cfg),
    .eval  (s1_eval)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld1)    s1_valid  <= pixel.valid;
      if (ld2)    s2_valid  <= s1_valid;
      if (ld3)    s3_valid  <= s2_valid;
      if (ld4)    s4_valid  <= s3_valid;
      if (ld_out) out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_red   <= pixel.red;
      s1_green <= pixel.green;
      s1_blue  <= pixel.blue;
      s1_last  <= pixel.last_pixel;
    end
    if (ld2) begin
      s2_eval <= s1_eval;
      s2_last <= s1_last;
    end
  end

  // saturating increments for the pixel leaving stage 2
  assign count_advance = s2_valid && ld3;

  always_comb begin
    neutral_count_next = neutral_count;
    midtone_count_next = midtone_count;
    pixel_count_next   = pixel_count;
    if (s2_eval.neutral && neutral_count != COUNT_MAX) begin
      neutral_count_next = neutral_count + COUNT_ONE;
    end
    if (s2_eval.midtone && midtone_count != COUNT_MAX) begin
      midtone_count_next = midtone_count + COUNT_ONE;
    end
    if (pixel_count != COUNT_MAX) begin
      pixel_count_next = pixel_count + COUNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neutral_count <= '0;
      midtone_count <= '0;
      pixel_count   <= '0;
    end else if (count_advance) begin
      if (s2_last) begin
        // page closed: start the next page from zero
        neutral_count <= '0;
        midtone_count <= '0;
        pixel_count   <= '0;
      end else begin
        neutral_count <= neutral_count_next;
        midtone_count <= midtone_count_next;
        pixel_count   <= pixel_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_luma          <= s2_eval.luma;
      s3_neutral       <= s2_eval.neutral;
      s3_last          <= s2_last;
      s3_neutral_count <= neutral_count_next;
      s3_midtone_count <= midtone_count_next;
      s3_pixel_count   <= pixel_count_next;
    end
    if (ld4) begin
      s4_luma           <= s3_luma;
      s4_neutral        <= s3_neutral;
      s4_last           <= s3_last;
      s4_neutral_scaled <= PROD_WIDTH'(s3_neutral_count) * PROD_WIDTH'(PCT_SCALE);
      s4_gray_limit     <= PROD_WIDTH'(cfg.gray_percent) * PROD_WIDTH'(s3_pixel_count);
      s4_midtone_scaled <= PROD_WIDTH'(s3_midtone_count) * PROD_WIDTH'(PCT_SCALE);
      s4_midtone_limit  <= PROD_WIDTH'(cfg.midtone_percent) * PROD_WIDTH'(s3_pixel_count);
    end
  end

  // output register: compare products, verdicts only at page end
  logic page_gray_next;

  assign page_gray_next = s4_last && (s4_neutral_scaled > s4_gray_limit);

  always_ff @(posedge clk) begin
    if (ld_out) begin
      result.luma          <= s4_luma;
      result.pixel_neutral <= s4_neutral;
      result.page_end      <= s4_last;
      result.page_gray     <= page_gray_next;
      result.bilevel_ready <= page_gray_next && (s4_midtone_scaled < s4_midtone_limit);
    end
  end

  assign result.valid = out_valid;

  `GPC_ASSERT(a_counts_clear_after_page, clk, rst, count_advance && s2_last |=> neutral_count == '0 && midtone_count == '0 && pixel_count == '0)
  `GPC_ASSERT(a_pixel_count_bounds, clk, rst, pixel_count >= neutral_count && pixel_count >= midtone_count)
  `GPC_ASSERT(a_verdicts_only_at_end, clk, rst, result.valid && !result.page_end |-> !result.page_gray && !result.bilevel_ready)
  `GPC_ASSERT_ALWAYS(a_reset_empties_output, clk, rst |=> !result.valid && !s1_valid)

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gray page classifier testbench
// Streams RGB pixels in pages through the core under several register
// settings. A predictor computes luma, the neutral flag and the page verdicts
// for every accepted pixel, and each result transaction is checked against it.
// The counters are built narrow here so that long pages saturate them.
// ----------------------------------------------------------------------------
module testbench;
  import gpc_pkg::*;

  localparam int unsigned TALLY_WIDTH   = 8;
  localparam int unsigned IDLE_PERCENT  = 9;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_PIXELS  = 12;
  localparam int unsigned LONG_PAGE     = 300;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       pixel_neutral;
    logic       page_end;
    logic       page_gray;
    logic       bilevel_ready;
  } verdict_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       write_enable = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] write_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  write_data = '0;

  gpc_pixel_if  pixel ();
  gpc_result_if result ();

  gray_page_classifier_core #(
    .COUNT_WIDTH(TALLY_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .pixel(pixel),
    .result(result),
    .write_enable(write_enable),
    .write_index(write_index),
    .write_data(write_data)
  );

  pixel_t   pending_pixels[$];
  verdict_t expected_results[$];

  cfg_t                   cfg_now = CFG_RESET;
  logic [TALLY_WIDTH-1:0] neutral_tally = '0;
  logic [TALLY_WIDTH-1:0] midtone_tally = '0;
  logic [TALLY_WIDTH-1:0] pixel_tally = '0;

  int unsigned pixels_queued = 0;
  int unsigned pixels_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned failures = 0;
  logic        pixel_taken = 1'b0;
  logic        steady;

  // no idling on either side through this stretch of the stream
  assign steady = (pixels_accepted >= 250) && (pixels_accepted < 450);

  initial begin
    clk = 1'b0;
    pixel.valid = 1'b0;
    pixel.red = '0;
    pixel.green = '0;
    pixel.blue = '0;
    pixel.last_pixel = 1'b0;
    result.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic verdict_t classify_pixel(pixel_t p);
    verdict_t v;
    int       d_rg;
    int       d_rb;
    int       d_gb;
    logic     is_midtone;
    logic     gray;
    logic     few_mid;
    d_rg = int'(p.red) - int'(p.green);
    d_rb = int'(p.red) - int'(p.blue);
    d_gb = int'(p.green) - int'(p.blue);
    if (d_rg < 0) d_rg = -d_rg;
    if (d_rb < 0) d_rb = -d_rb;
    if (d_gb < 0) d_gb = -d_gb;
    v = '0;
    v.luma = 8'((77 * int'(p.red) + 150 * int'(p.green) + 29 * int'(p.blue)) >> 8);
    v.pixel_neutral = (d_rg < int'(cfg_now.neutral_tolerance)) &&
                      (d_rb < int'(cfg_now.neutral_tolerance)) &&
                      (d_gb < int'(cfg_now.neutral_tolerance));
    is_midtone = (v.luma > cfg_now.band_low) && (v.luma < cfg_now.band_high);
    v.page_end = p.last_pixel;
    // hold each tally at all ones
    if (v.pixel_neutral && neutral_tally != '1) neutral_tally++;
    if (is_midtone && midtone_tally != '1) midtone_tally++;
    if (pixel_tally != '1) pixel_tally++;
    if (p.last_pixel) begin
      gray = longint'(neutral_tally) * 100 >
             longint'(cfg_now.gray_percent) * longint'(pixel_tally);
      few_mid = longint'(midtone_tally) * 100 <
                longint'(cfg_now.midtone_percent) * longint'(pixel_tally);
      v.page_gray = gray;
      v.bilevel_ready = gray && few_mid;
      neutral_tally = '0;
      midtone_tally = '0;
      pixel_tally = '0;
    end
    return v;
  endfunction

  function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    verdict_t got;
    verdict_t want;
    if (rst) begin
      pixel_taken <= 1'b0;
    end else begin
      pixel_taken <= pixel.valid && pixel.ready;
      if (write_enable) begin
        case (write_index)
          CFG_NEUTRAL_TOLERANCE: cfg_now.neutral_tolerance = write_data;
          CFG_GRAY_PERCENT:      cfg_now.gray_percent = write_data[6:0];
          CFG_BAND_LOW:          cfg_now.band_low = write_data;
          CFG_BAND_HIGH:         cfg_now.band_high = write_data;
          CFG_MIDTONE_PERCENT:   cfg_now.midtone_percent = write_data[6:0];
          default: ;
        endcase
      end
      if (pixel.valid && pixel.ready) begin
        expected_results.push_back(classify_pixel({pixel.red, pixel.green, pixel.blue,
                                                   pixel.last_pixel}));
        pixels_accepted++;
      end
      if (result.valid && result.ready) begin
        results_seen++;
        got = {result.luma, result.pixel_neutral, result.page_end, result.page_gray,
               result.bilevel_ready};
        if (expected_results.size() == 0) begin
          $error("result transaction with no pixel pending: luma %0d", got.luma);
          failures++;
        end else begin
          want = expected_results.pop_front();
          compare_field("luma", want.luma, got.luma);
          compare_field("pixel_neutral", 8'(want.pixel_neutral), 8'(got.pixel_neutral));
          compare_field("page_end", 8'(want.page_end), 8'(got.page_end));
          compare_field("page_gray", 8'(want.page_gray), 8'(got.page_gray));
          compare_field("bilevel_ready", 8'(want.bilevel_ready), 8'(got.bilevel_ready));
        end
      end
    end
  end

  always @(negedge clk) begin : pixel_driver
    pixel_t next_pixel;
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (!pixel.valid || pixel_taken) begin
      if (pending_pixels.size() != 0 && (steady || $urandom_range(99, 0) >= IDLE_PERCENT)) begin
        next_pixel = pending_pixels.pop_front();
        pixel.valid <= 1'b1;
        pixel.red <= next_pixel.red;
        pixel.green <= next_pixel.green;
        pixel.blue <= next_pixel.blue;
        pixel.last_pixel <= next_pixel.last_pixel;
      end else begin
        pixel.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= steady || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end
  end

  task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    pending_pixels.push_back({r, g, b, last});
    pixels_queued++;
  endtask

  task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] data);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic load_config(cfg_t c);
    write_register(CFG_NEUTRAL_TOLERANCE, c.neutral_tolerance);
    write_register(CFG_GRAY_PERCENT, {1'b0, c.gray_percent});
    write_register(CFG_BAND_LOW, c.band_low);
    write_register(CFG_BAND_HIGH, c.band_high);
    write_register(CFG_MIDTONE_PERCENT, {1'b0, c.midtone_percent});
  endtask

  // wait for every result, then let the pipeline empty before touching registers
  task automatic drain();
    wait (results_seen == pixels_queued);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // build one page; shares are percent chances of a neutral and an in-band pixel
  task automatic queue_page(int unsigned length, int unsigned neutral_share,
                            int unsigned midtone_share);
    int unsigned base;
    int unsigned spread;
    for (int unsigned n = 0; n < length; n++) begin
      if ($urandom_range(99, 0) < midtone_share && cfg_now.band_low + 1 < cfg_now.band_high)
        base = $urandom_range(cfg_now.band_high - 1, cfg_now.band_low + 1);
      else
        base = $urandom_range(255, 0);
      if ($urandom_range(99, 0) < neutral_share) begin
        spread = (cfg_now.neutral_tolerance == 0) ? 0 : cfg_now.neutral_tolerance - 1;
        if (base > 255 - spread) base = 255 - spread;
        queue_pixel(8'(base + $urandom_range(spread, 0)), 8'(base + $urandom_range(spread, 0)),
                    8'(base + $urandom_range(spread, 0)), n == length - 1);
      end else begin
        queue_pixel(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                    8'($urandom_range(255, 0)), n == length - 1);
      end
    end
  endtask

  initial begin : stimulus
    cfg_t        setting;
    int unsigned phase_items;
    int unsigned length;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed pixels under the reset settings
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd0, 8'd1, 8'd1, 1'b0);
    queue_pixel(8'd1, 8'd0, 8'd1, 1'b1);
    queue_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    queue_pixel(8'd2, 8'd0, 8'd0, 1'b1);
    queue_pixel(8'd128, 8'd128, 8'd128, 1'b1);
    queue_pixel(8'd50, 8'd50, 8'd50, 1'b0);
    queue_pixel(8'd51, 8'd51, 8'd51, 1'b0);
    queue_pixel(8'd199, 8'd199, 8'd199, 1'b0);
    queue_pixel(8'd200, 8'd200, 8'd200, 1'b1);
    queue_pixel(8'd170, 8'd85, 8'd170, 1'b0);
    queue_pixel(8'd85, 8'd170, 8'd85, 1'b1);
    drain();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      // fields: tolerance, gray percent, band low, band high, mid-tone percent
      case (phase)
        0: setting = CFG_RESET;
        1: setting = '{8'd0, 7'd0, 8'd0, 8'd255, 7'd0};
        2: setting = '{8'd255, 7'd100, 8'd255, 8'd0, 7'd127};
        3: setting = '{8'd8, 7'd50, 8'd100, 8'd150, 7'd30};
        4: setting = '{8'd1, 7'd127, 8'd0, 8'd0, 7'd100};
        5: setting = '{8'd4, 7'd99, 8'd254, 8'd255, 7'd1};
        6: setting = '{8'd12, 7'd60, 8'd40, 8'd220, 7'd50};
        default: begin
          setting.neutral_tolerance = $urandom_range(1, 0) ? 8'($urandom_range(16, 0))
                                                           : 8'($urandom_range(255, 0));
          setting.gray_percent = 7'($urandom_range(110, 0));
          setting.band_low = 8'($urandom_range(255, 0));
          setting.band_high = 8'($urandom_range(255, 0));
          setting.midtone_percent = 7'($urandom_range(110, 0));
        end
      endcase
      load_config(setting);
      if (phase == 2) begin
        // writes outside the register list must leave the settings alone
        for (int idx = CFG_MIDTONE_PERCENT + 1; idx < 2 ** CFG_INDEX_WIDTH; idx++)
          write_register(CFG_INDEX_WIDTH'(idx), '1);
      end

      phase_items = 0;
      // long pages drive the pixel tally into saturation
      if (phase == 3) begin
        queue_page(LONG_PAGE, 95, 5);
        phase_items = LONG_PAGE;
      end else if (phase == 6) begin
        queue_page(LONG_PAGE - 40, 80, 90);
        phase_items = LONG_PAGE - 40;
      end
      while (phase_items < PHASE_PIXELS) begin
        length = ($urandom_range(99, 0) < 70) ? $urandom_range(12, 1) : $urandom_range(60, 13);
        queue_page(length, $urandom_range(100, 0), $urandom_range(100, 0));
        phase_items += length;
      end
      drain();
    end

    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
